/* rtl/core/sca_pkg.sv */
package sca_pkg;

  localparam logic [16:0] MaxSize = 17'h18000;
  localparam logic [16:0] SmallMax = 17'd2048;

  localparam logic RegHeapBase  = 1'b0;
  localparam logic RegHeapPages = 1'b1;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_TOO_LARGE = 3'd1,
    STS_HEAP_FULL = 3'd2,
    STS_RANGE     = 3'd3,
    STS_MISMATCH  = 3'd4,
    STS_MISALIGN  = 3'd5,
    STS_DOUBLE    = 3'd6
  } sca_status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_ALLOC,
    ST_RUN,
    ST_POP,
    ST_PCNT_RD,
    ST_PCNT_WR,
    ST_FPAGE,
    ST_FCHK_RD,
    ST_FCHK,
    ST_FGRAN,
    ST_DONE
  } sca_state_e;

  typedef struct packed {
    logic [16:0] size;
    logic [4:0]  cls;
  } sca_dec_req_t;

  typedef struct packed {
    logic [4:0]  pick_cls;
    logic [4:0]  np;
    logic [12:0] egran;
    logic [8:0]  fc;
    logic [11:0] amask;
  } sca_class_info_t;

endpackage

/* rtl/core/sca_decode.sv */
module sca_decode (
  input  sca_pkg::sca_dec_req_t    req_i,
  output sca_pkg::sca_class_info_t info_o
);
  import sca_pkg::*;

  logic [4:0] pick;
  logic [4:0] np;

  always_comb begin
    pick = 5'd7;
    if (req_i.size <= SmallMax) begin
      for (int k = 6; k >= 0; k--) begin
        if ((17'd16 << k) >= req_i.size) begin
          pick = 5'(k);
        end
      end
    end else begin
      pick = 5'(18'd7 + ((18'(req_i.size) + 18'd4095) >> 12));
    end
  end

  always_comb begin
    np = 5'd1;
    info_o.pick_cls = pick;
    if (req_i.cls < 5'd8) begin
      info_o.egran = 13'd1 << req_i.cls[2:0];
      info_o.fc    = 9'(12'd256 >> req_i.cls[2:0]);
      info_o.amask = 12'((13'd16 << req_i.cls[2:0]) - 13'd1);
    end else begin
      np = req_i.cls - 5'd7;
      info_o.egran = 13'(np) << 8;
      info_o.fc    = 9'd1;
      info_o.amask = 12'hFFF;
    end
    info_o.np = np;
  end

endmodule

/* rtl/core/sca_engine.sv */
module sca_engine #(
  parameter int HEAP_PAGES = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [31:0]              pool_base_i,
  input  logic [8:0]               heap_pages_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     in_mode_i,
  input  logic [16:0]              in_size_i,
  input  logic [31:0]              in_addr_i,
  output sca_pkg::sca_dec_req_t    dec_o,
  input  sca_pkg::sca_class_info_t info_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [31:0]              out_addr_o,
  output logic [4:0]               out_cls_o,
  output logic [2:0]               out_status_o
);
  import sca_pkg::*;

  localparam int Granules = HEAP_PAGES * 256;
  localparam int PW  = $clog2(HEAP_PAGES);
  localparam int GW  = $clog2(Granules);
  localparam int PCW = $clog2(HEAP_PAGES + 1);

  sca_state_e state_q, state_d;
  logic [GW-1:0] clr_q, clr_d;
  logic          mode_q, mode_d;
  logic [16:0]   size_q, size_d;
  logic [31:0]   addr_q, addr_d, off_q, off_d;
  logic [4:0]    c_q, c_d, i_q, i_d;
  logic [GW-1:0] g_q, g_d;
  logic [PW-1:0] p_q, p_d;
  logic [31:0]   res_addr_q, res_addr_d;
  logic [4:0]    res_cls_q, res_cls_d;
  sca_status_e   res_st_q, res_st_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_addr_q, out_addr_d;
  logic [4:0]    out_cls_q, out_cls_d;
  sca_status_e   out_st_q, out_st_d;

  logic [GW:0]   head_q [32];
  logic [GW:0]   head_d [32];
  logic [15:0]   fcnt_q [32];
  logic [15:0]   fcnt_d [32];
  logic [15:0]   lcnt_q [32];
  logic [15:0]   lcnt_d [32];
  logic [GW-1:0] rnext_q [32];
  logic [GW-1:0] rnext_d [32];
  logic [8:0]    rleft_q [32];
  logic [8:0]    rleft_d [32];
  logic [PCW-1:0] bump_q, bump_d;

  logic [15:0]   page_mem [HEAP_PAGES];
  logic [15:0]   pg_rd_q;
  logic          pg_we;
  logic [PW-1:0] pg_waddr, pg_raddr;
  logic [15:0]   pg_wdata;

  logic [GW:0]   link_mem [Granules];
  logic          flag_mem [Granules];
  logic [GW:0]   link_rd_q;
  logic          flag_rd_q;
  logic          link_we, flag_we, flag_wdata;
  logic [GW-1:0] gr_waddr, gr_raddr;
  logic [GW:0]   link_wdata;

  logic [PCW-1:0] eff;
  logic [31:0]    off, pa;
  logic [GW-1:0]  gsel;
  logic           fin;

  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      page_mem[pg_waddr] <= pg_wdata;
    end
    pg_rd_q <= page_mem[pg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[gr_waddr] <= link_wdata;
    end
    if (flag_we) begin
      flag_mem[gr_waddr] <= flag_wdata;
    end
    link_rd_q <= link_mem[gr_raddr];
    flag_rd_q <= flag_mem[gr_raddr];
  end

  assign eff = (32'(heap_pages_i) < 32'(HEAP_PAGES)) ? PCW'(heap_pages_i) : PCW'(HEAP_PAGES);
  assign off = addr_q - pool_base_i;
  assign pa  = 32'(p_q) + 32'(i_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign dec_o.size = size_q;
  assign dec_o.cls  = (state_q == ST_FPAGE) ? pg_rd_q[4:0] : c_q;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    mode_d = mode_q;
    size_d = size_q;
    addr_d = addr_q;
    off_d = off_q;
    c_d = c_q;
    i_d = i_q;
    g_d = g_q;
    p_d = p_q;
    res_addr_d = res_addr_q;
    res_cls_d = res_cls_q;
    res_st_d = res_st_q;
    out_valid_d = out_valid_q;
    out_addr_d = out_addr_q;
    out_cls_d = out_cls_q;
    out_st_d = out_st_q;
    head_d = head_q;
    fcnt_d = fcnt_q;
    lcnt_d = lcnt_q;
    rnext_d = rnext_q;
    rleft_d = rleft_q;
    bump_d = bump_q;
    pg_we = 1'b0;
    pg_waddr = '0;
    pg_raddr = '0;
    pg_wdata = '0;
    link_we = 1'b0;
    flag_we = 1'b0;
    flag_wdata = 1'b0;
    link_wdata = '0;
    gr_waddr = '0;
    gr_raddr = '0;
    gsel = '0;
    fin = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        flag_we = 1'b1;
        gr_waddr = clr_q;
        if (clr_q[7:0] == 8'd0) begin
          pg_we = 1'b1;
          pg_waddr = clr_q[GW-1:8];
        end
        clr_d = clr_q + GW'(1);
        if (clr_q == GW'(Granules - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d = in_mode_i;
          size_d = in_size_i;
          addr_d = in_addr_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_addr_d = '0;
        res_cls_d = '0;
        if (!mode_q) begin
          if (size_q > MaxSize) begin
            res_st_d = STS_TOO_LARGE;
            fin = 1'b1;
          end else begin
            c_d = info_i.pick_cls;
            state_d = ST_ALLOC;
          end
        end else if (addr_q == 32'd0) begin
          res_st_d = STS_OK;
          fin = 1'b1;
        end else if (addr_q < pool_base_i || off >= (32'(eff) << 12)) begin
          res_st_d = STS_RANGE;
          fin = 1'b1;
        end else begin
          off_d = off;
          p_d = off[PW+11:12];
          pg_raddr = off[PW+11:12];
          state_d = ST_FPAGE;
        end
      end
      ST_ALLOC: begin
        res_cls_d = c_q;
        if (head_q[c_q] != '0) begin
          gsel = GW'(head_q[c_q] - (GW+1)'(1));
          g_d = gsel;
          gr_raddr = gsel;
          state_d = ST_POP;
        end else if (rleft_q[c_q] == 9'd0) begin
          if (32'(bump_q) + 32'(info_i.np) > 32'(eff)) begin
            res_addr_d = '0;
            res_st_d = STS_HEAP_FULL;
            fin = 1'b1;
          end else begin
            i_d = '0;
            state_d = ST_RUN;
          end
        end else begin
          gsel = rnext_q[c_q];
          g_d = gsel;
          rleft_d[c_q] = rleft_q[c_q] - 9'd1;
          rnext_d[c_q] = rnext_q[c_q] + GW'(info_i.egran);
          lcnt_d[c_q] = lcnt_q[c_q] + 16'd1;
          p_d = gsel[GW-1:8];
          i_d = '0;
          state_d = ST_PCNT_RD;
        end
      end
      ST_RUN: begin
        // fresh run: the first element is already taken from the first page
        pg_we = 1'b1;
        pg_waddr = PW'(32'(bump_q) + 32'(i_q));
        pg_wdata = {1'b1, 1'b0, info_i.fc - 9'd1, c_q};
        i_d = i_q + 5'd1;
        if (i_q == info_i.np - 5'd1) begin
          gsel = GW'(32'(bump_q) << 8);
          g_d = gsel;
          rnext_d[c_q] = gsel + GW'(info_i.egran);
          rleft_d[c_q] = info_i.fc - 9'd1;
          bump_d = bump_q + PCW'(info_i.np);
          lcnt_d[c_q] = lcnt_q[c_q] + 16'd1;
          res_addr_d = pool_base_i + (32'(gsel) << 4);
          res_cls_d = c_q;
          res_st_d = STS_OK;
          fin = 1'b1;
        end
      end
      ST_POP: begin
        head_d[c_q] = link_rd_q;
        flag_we = 1'b1;
        gr_waddr = g_q;
        fcnt_d[c_q] = fcnt_q[c_q] - 16'd1;
        lcnt_d[c_q] = lcnt_q[c_q] + 16'd1;
        p_d = g_q[GW-1:8];
        i_d = '0;
        state_d = ST_PCNT_RD;
      end
      ST_PCNT_RD: begin
        res_addr_d = mode_q ? 32'd0 : pool_base_i + (32'(g_q) << 4);
        res_cls_d = c_q;
        res_st_d = STS_OK;
        if (pa < 32'(HEAP_PAGES)) begin
          pg_raddr = PW'(pa);
          state_d = ST_PCNT_WR;
        end else begin
          fin = 1'b1;
        end
      end
      ST_PCNT_WR: begin
        pg_we = 1'b1;
        pg_waddr = PW'(pa);
        pg_wdata = {pg_rd_q[15:14], pg_rd_q[13:5] + (mode_q ? 9'd1 : 9'h1FF), pg_rd_q[4:0]};
        i_d = i_q + 5'd1;
        if (i_q + 5'd1 == info_i.np) begin
          fin = 1'b1;
        end else begin
          state_d = ST_PCNT_RD;
        end
      end
      ST_FPAGE: begin
        c_d = pg_rd_q[4:0];
        res_addr_d = '0;
        res_cls_d = pg_rd_q[4:0];
        if (!pg_rd_q[15]) begin
          res_st_d = STS_MISMATCH;
          fin = 1'b1;
        end else if ((off_q[11:0] & info_i.amask) != 12'd0) begin
          res_st_d = STS_MISALIGN;
          fin = 1'b1;
        end else begin
          i_d = 5'd1;
          state_d = ST_FCHK_RD;
        end
      end
      ST_FCHK_RD: begin
        if (i_q == info_i.np) begin
          gr_raddr = off_q[GW+3:4];
          g_d = off_q[GW+3:4];
          state_d = ST_FGRAN;
        end else if (pa >= 32'(eff)) begin
          res_st_d = STS_MISMATCH;
          fin = 1'b1;
        end else begin
          pg_raddr = PW'(pa);
          state_d = ST_FCHK;
        end
      end
      ST_FCHK: begin
        if (pg_rd_q[4:0] != c_q) begin
          res_st_d = STS_MISMATCH;
          fin = 1'b1;
        end else begin
          i_d = i_q + 5'd1;
          state_d = ST_FCHK_RD;
        end
      end
      ST_FGRAN: begin
        if (flag_rd_q) begin
          res_st_d = STS_DOUBLE;
          fin = 1'b1;
        end else begin
          link_we = 1'b1;
          flag_we = 1'b1;
          flag_wdata = 1'b1;
          gr_waddr = g_q;
          link_wdata = head_q[c_q];
          head_d[c_q] = (GW+1)'(g_q) + (GW+1)'(1);
          lcnt_d[c_q] = lcnt_q[c_q] - 16'd1;
          fcnt_d[c_q] = fcnt_q[c_q] + 16'd1;
          p_d = off_q[PW+11:12];
          i_d = '0;
          state_d = ST_PCNT_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_addr_d = res_addr_q;
          out_cls_d = res_cls_q;
          out_st_d = res_st_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (fin) begin
      state_d = ST_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
      head_q <= '{default: '0};
      fcnt_q <= '{default: '0};
      lcnt_q <= '{default: '0};
      rnext_q <= '{default: '0};
      rleft_q <= '{default: '0};
      bump_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      out_valid_q <= out_valid_d;
      head_q <= head_d;
      fcnt_q <= fcnt_d;
      lcnt_q <= lcnt_d;
      rnext_q <= rnext_d;
      rleft_q <= rleft_d;
      bump_q <= bump_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    size_q <= size_d;
    addr_q <= addr_d;
    off_q <= off_d;
    c_q <= c_d;
    i_q <= i_d;
    g_q <= g_d;
    p_q <= p_d;
    res_addr_q <= res_addr_d;
    res_cls_q <= res_cls_d;
    res_st_q <= res_st_d;
    out_addr_q <= out_addr_d;
    out_cls_q <= out_cls_d;
    out_st_q <= out_st_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_addr_o = out_addr_q;
  assign out_cls_o = out_cls_q;
  assign out_status_o = out_st_q;

endmodule

/* rtl/core/size_class_bin_allocator_top.sv */
// Size-class bin allocator.
// Input stream: s_axis_tuser selects allocate (0) or free (1); s_axis_tdata
// carries the requested size and the address to free. One result transaction
// per request on the m_axis channel: address, size class and status.
// Configuration: cfg_index_i 0 writes the heap base, 1 the page count; write
// only while no request is in flight.
// Flow: one request at a time. Too large, null and out-of-range requests end
// after the check, heap full at the allocation step, an unused page or
// misalignment on free at the first page read. A fresh-run allocate writes
// one page record per page of the element (up to 24 pages); a partly used
// run and a free-list pop read and rewrite the count of each page. A free
// checks the class of every page spanned, then the granule flag, then
// updates each page count; a double free stops at the flag, a mismatch on a
// later page sooner. s_axis_tready rises with the result. A result sits in
// the output register, so the next request is taken while it waits.
// Reset: a clearing pass over all HEAP_PAGES*256 granules (65536 by default) zeroes
// the granule free flags and the page records; s_axis_tready stays low.
// A stalled receiver holds the result; after one more request completes,
// the block waits with s_axis_tready low until the output drains.
module size_class_bin_allocator_top #(
  parameter int HEAP_PAGES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // req_size[16:0], address[48:17], zero pad
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_address[31:0], size_class[36:32], status[39:37]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import sca_pkg::*;

  logic [31:0] pool_base_q;
  logic [8:0]  heap_pages_q;
  sca_dec_req_t    dec_req;
  sca_class_info_t dec_info;
  logic [31:0] out_addr;
  logic [4:0]  out_cls;
  logic [2:0]  out_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      heap_pages_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegHeapBase:  pool_base_q <= cfg_data_i;
        RegHeapPages: heap_pages_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  sca_decode u_decode (
    .req_i  (dec_req),
    .info_o (dec_info)
  );

  sca_engine #(
    .HEAP_PAGES (HEAP_PAGES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pool_base_i  (pool_base_q),
    .heap_pages_i (heap_pages_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tuser),
    .in_size_i    (s_axis_tdata[16:0]),
    .in_addr_i    (s_axis_tdata[48:17]),
    .dec_o        (dec_req),
    .info_i       (dec_info),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_cls_o    (out_cls),
    .out_status_o (out_st)
  );

  assign m_axis_tdata = {out_st, out_cls, out_addr};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_err_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39:37] != STS_OK |-> m_axis_tdata[31:0] == 32'd0)
    else $error("error result carries an address");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:37] != 3'd7)
    else $error("undefined status code");

endmodule
